### rtl/ehvm_pkg.sv
// ----------------------------------------------------------------------------
// ehvm_pkg
// Shared types and constants for the encoder health and velocity monitor.
// ----------------------------------------------------------------------------
package ehvm_pkg;

  localparam int MAX_AXES  = 4;
  localparam int AXIS_W    = 2;
  localparam int CNT_W     = 3;   // holds 0..MAX_AXES
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 32;

  localparam logic [19:0] VEL_SCALE = 20'd1000000;  // us per second
  localparam logic [7:0]  ERR_MAX   = 8'hFF;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_COUNT       = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_READ_INTERVAL_US = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_THRESHOLD  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DT_US        = 4'd3;

  localparam logic [2:0]  RST_AXIS_COUNT       = 3'd2;
  localparam logic [19:0] RST_READ_INTERVAL_US = 20'd2000;
  localparam logic [7:0]  RST_ERROR_THRESHOLD  = 8'd25;
  localparam logic [15:0] RST_MIN_DT_US        = 16'd100;

  typedef struct packed {
    logic [31:0]        time_us;
    logic [AXIS_W-1:0]  axis;
    logic               sensor_ok;
    logic signed [31:0] angle_in;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic               angle_valid;
    logic signed [31:0] angle_out;
    logic signed [31:0] velocity;
    logic               emergency_stop;
  } out_item_t;

  // one entry of the per-axis state memory
  typedef struct packed {
    logic               valid;
    logic [7:0]         err;
    logic signed [31:0] angle;
    logic signed [31:0] vel;
  } axis_ent_t;

  typedef struct packed {
    logic               go;
    logic signed [32:0] diff;
    logic [31:0]        dt;
  } vel_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] vel;
  } vel_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_DONE
  } ctrl_state_t;

  typedef enum logic [2:0] {
    V_IDLE,
    V_MUL,
    V_CHK,
    V_DIV,
    V_OUT
  } vel_state_t;

endpackage

### rtl/ehvm_axis_ram.sv
// ----------------------------------------------------------------------------
// ehvm_axis_ram
// Per-axis state memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ehvm_axis_ram (
  input  logic                      clk,
  input  logic                      we,
  input  logic [ehvm_pkg::AXIS_W-1:0] waddr,
  input  ehvm_pkg::axis_ent_t       wdata,
  input  logic                      re,
  input  logic [ehvm_pkg::AXIS_W-1:0] raddr,
  output ehvm_pkg::axis_ent_t       rdata
);

  ehvm_pkg::axis_ent_t mem [ehvm_pkg::MAX_AXES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/ehvm_vel_unit.sv
// ----------------------------------------------------------------------------
// ehvm_vel_unit
// Velocity = diff * 1e6 / dt, truncated toward zero, saturated to 32 bits.
// A multiply step and a range check, then a restoring divider at one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ehvm_vel_unit (
  input  logic               clk,
  input  logic               rst,
  input  ehvm_pkg::vel_req_t req,
  output ehvm_pkg::vel_rsp_t rsp
);

  ehvm_pkg::vel_state_t state, state_next;

  logic        neg;
  logic [32:0] mag;
  logic [31:0] dt;
  logic [52:0] prod;
  logic        ovf;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [4:0]  cnt;

  logic [32:0] trial;
  logic        fits;

  assign trial = {rem, quo[31]};
  assign fits  = trial >= {1'b0, dt};

  always_comb begin
    state_next = state;
    unique case (state)
      ehvm_pkg::V_IDLE: if (req.go) state_next = ehvm_pkg::V_MUL;
      ehvm_pkg::V_MUL:  state_next = ehvm_pkg::V_CHK;
      ehvm_pkg::V_CHK:  state_next = (prod[52:32] >= 21'(dt)) && (dt[31:21] == 11'd0)
                                     ? ehvm_pkg::V_OUT : ehvm_pkg::V_DIV;
      ehvm_pkg::V_DIV:  if (cnt == 5'd0) state_next = ehvm_pkg::V_OUT;
      ehvm_pkg::V_OUT:  state_next = ehvm_pkg::V_IDLE;
      default:          state_next = ehvm_pkg::V_IDLE;
    endcase
  end

  always_comb begin
    rsp.done = (state == ehvm_pkg::V_OUT);
    if (neg) begin
      rsp.vel = (ovf || quo[31]) ? 32'sh8000_0000 : -$signed(quo);
    end else begin
      rsp.vel = (ovf || quo[31]) ? 32'sh7FFF_FFFF : $signed(quo);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ehvm_pkg::V_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ehvm_pkg::V_IDLE: begin
        if (req.go) begin
          neg <= req.diff[32];
          mag <= req.diff[32] ? 33'(-req.diff) : 33'(req.diff);
          dt  <= req.dt;
        end
      end
      ehvm_pkg::V_MUL: begin
        prod <= 53'(mag) * 53'(ehvm_pkg::VEL_SCALE);
      end
      ehvm_pkg::V_CHK: begin
        // upper part already >= dt means the quotient needs more than 32 bits
        ovf <= (prod[52:32] >= 21'(dt)) && (dt[31:21] == 11'd0);
        rem <= 32'(prod[52:32]);
        quo <= prod[31:0];
        cnt <= 5'd31;
      end
      ehvm_pkg::V_DIV: begin
        rem <= fits ? 32'(trial - {1'b0, dt}) : trial[31:0];
        quo <= {quo[30:0], fits};
        cnt <= cnt - 5'd1;
      end
      ehvm_pkg::V_OUT: begin
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/encoder_health_velocity_monitor.sv
// ----------------------------------------------------------------------------
// encoder_health_velocity_monitor
// Per-axis encoder error counting, sticky stop and velocity estimate.
//
//   channel  signals                              direction
//   in       in_valid  in_ready  in_item          request in
//   out      out_valid out_ready out_item         result out
//   cfg      cfg_valid cfg_ready cfg_index cfg_data  register write in
//
// One request at a time. A request passes READ, then DIV if a velocity is needed,
// then DONE, which loads out_item once any held result is taken by out_ready. A
// velocity adds a multiply, a range check and a 32-step serial divide; the divide
// is skipped on overflow. Axis state sits in a 4-entry RAM read at accept and
// written back at the end; a next request is taken while the previous result
// waits in out_item. Synchronous reset, no clearing pass: reset state comes
// from per-entry flags. cfg_ready is always high.
// ----------------------------------------------------------------------------
module encoder_health_velocity_monitor (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  ehvm_pkg::in_item_t               in_item,
  output logic                             out_valid,
  input  logic                             out_ready,
  output ehvm_pkg::out_item_t              out_item,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ehvm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ehvm_pkg::CFG_DAT_W-1:0]   cfg_data
);

  // configuration
  logic [2:0]  axis_count;
  logic [19:0] read_interval_us;
  logic [7:0]  error_threshold;
  logic [15:0] min_dt_us;

  // pass state
  logic [31:0] last_read_time;
  logic        ever_read;
  logic        pass_open;
  logic [31:0] pass_dt_us;
  logic        stop_flag;

  // entry flags: written since reset, cleared as inactive axis
  logic [ehvm_pkg::MAX_AXES-1:0] wr_ok;
  logic [ehvm_pkg::MAX_AXES-1:0] clr;

  ehvm_pkg::ctrl_state_t state, state_next;
  ehvm_pkg::in_item_t    itm;
  ehvm_pkg::axis_ent_t   ent;
  logic                  upd;

  ehvm_pkg::axis_ent_t rd;
  ehvm_pkg::axis_ent_t eff;
  ehvm_pkg::axis_ent_t nxt;
  ehvm_pkg::vel_req_t  vreq;
  ehvm_pkg::vel_rsp_t  vrsp;

  logic                         in_acc;
  logic                         ram_we;
  logic                         out_load;
  logic                         need_vel;
  logic                         active;
  logic                         stop_hit;
  logic [ehvm_pkg::CNT_W-1:0]   n_act;
  logic [31:0]                  elapsed;
  logic                         throttled;
  logic [7:0]                   err_inc;
  logic [ehvm_pkg::MAX_AXES-1:0] inact_mask;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;

  assign n_act = (axis_count > 3'(ehvm_pkg::MAX_AXES)) ? 3'(ehvm_pkg::MAX_AXES) : axis_count;
  assign elapsed   = in_item.time_us - last_read_time;
  assign throttled = ever_read && (elapsed < {12'd0, read_interval_us});

  always_comb begin
    for (int i = 0; i < ehvm_pkg::MAX_AXES; i++) begin
      inact_mask[i] = 3'(i) >= n_act;
    end
  end

  ehvm_axis_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (itm.axis),
    .wdata (ent),
    .re    (in_acc),
    .raddr (in_item.axis),
    .rdata (rd)
  );

  ehvm_vel_unit u_vel (
    .clk (clk),
    .rst (rst),
    .req (vreq),
    .rsp (vrsp)
  );

  // stored entry as seen after reset and inactive-axis clears
  always_comb begin
    eff       = rd;
    eff.angle = wr_ok[itm.axis] ? rd.angle : 32'sd0;
    if (!wr_ok[itm.axis] || clr[itm.axis]) begin
      eff.valid = 1'b0;
      eff.err   = 8'd0;
      eff.vel   = 32'sd0;
    end
  end

  always_comb begin
    active   = pass_open && ({1'b0, itm.axis} < n_act);
    err_inc  = (eff.err == ehvm_pkg::ERR_MAX) ? ehvm_pkg::ERR_MAX : eff.err + 8'd1;
    nxt      = eff;
    need_vel = 1'b0;
    stop_hit = 1'b0;
    if (active) begin
      if (itm.sensor_ok) begin
        nxt.err   = 8'd0;
        nxt.angle = itm.angle_in;
        nxt.valid = 1'b1;
        nxt.vel   = 32'sd0;
        need_vel  = (pass_dt_us > {16'd0, min_dt_us}) && eff.valid;
      end else begin
        nxt.err   = err_inc;
        nxt.valid = 1'b0;
        nxt.vel   = 32'sd0;
        stop_hit  = err_inc >= error_threshold;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ehvm_pkg::ST_IDLE: if (in_acc) state_next = ehvm_pkg::ST_READ;
      ehvm_pkg::ST_READ: state_next = need_vel ? ehvm_pkg::ST_DIV : ehvm_pkg::ST_DONE;
      ehvm_pkg::ST_DIV:  if (vrsp.done) state_next = ehvm_pkg::ST_DONE;
      ehvm_pkg::ST_DONE: if (!out_valid || out_ready) state_next = ehvm_pkg::ST_IDLE;
      default:           state_next = ehvm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == ehvm_pkg::ST_IDLE);
    out_load  = (state == ehvm_pkg::ST_DONE) && (!out_valid || out_ready);
    ram_we    = out_load && upd;
    vreq.go   = (state == ehvm_pkg::ST_READ) && need_vel;
    vreq.diff = {itm.angle_in[31], itm.angle_in} - {eff.angle[31], eff.angle};
    vreq.dt   = pass_dt_us;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ehvm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      axis_count       <= ehvm_pkg::RST_AXIS_COUNT;
      read_interval_us <= ehvm_pkg::RST_READ_INTERVAL_US;
      error_threshold  <= ehvm_pkg::RST_ERROR_THRESHOLD;
      min_dt_us        <= ehvm_pkg::RST_MIN_DT_US;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ehvm_pkg::REG_AXIS_COUNT:       axis_count       <= cfg_data[2:0];
        ehvm_pkg::REG_READ_INTERVAL_US: read_interval_us <= cfg_data[19:0];
        ehvm_pkg::REG_ERROR_THRESHOLD:  error_threshold  <= cfg_data[7:0];
        ehvm_pkg::REG_MIN_DT_US:        min_dt_us        <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // pass control and entry flags
  always_ff @(posedge clk) begin
    if (rst) begin
      last_read_time <= 32'd0;
      ever_read      <= 1'b0;
      pass_open      <= 1'b0;
      pass_dt_us     <= 32'd0;
      stop_flag      <= 1'b0;
      wr_ok          <= '0;
      clr            <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (in_acc && (in_item.axis == '0)) begin
        if (throttled) begin
          pass_open <= 1'b0;
        end else begin
          pass_open      <= 1'b1;
          pass_dt_us     <= ever_read ? elapsed : 32'd0;
          last_read_time <= in_item.time_us;
          ever_read      <= 1'b1;
          clr            <= clr | inact_mask;
        end
      end
      if (state == ehvm_pkg::ST_READ && stop_hit) begin
        stop_flag <= 1'b1;
      end
      if (ram_we) begin
        wr_ok[itm.axis] <= 1'b1;
        clr[itm.axis]   <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request payload and working entry
  always_ff @(posedge clk) begin
    if (in_acc) begin
      itm <= in_item;
    end
    if (state == ehvm_pkg::ST_READ) begin
      ent <= nxt;
      upd <= active;
    end
    if (state == ehvm_pkg::ST_DIV && vrsp.done) begin
      ent.vel <= vrsp.vel;
    end
    if (out_load) begin
      out_item.accepted       <= pass_open;
      out_item.angle_valid    <= ent.valid;
      out_item.angle_out      <= ent.angle;
      out_item.velocity       <= ent.valid ? ent.vel : 32'sd0;
      out_item.emergency_stop <= stop_flag;
    end
  end

  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    stop_flag |=> stop_flag)
    else $error("emergency stop dropped without reset");

  a_vel_zero_invalid: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.angle_valid || out_item.velocity == 32'sd0))
    else $error("velocity reported for invalid axis");

  a_vel_go_state: assert property (@(posedge clk) disable iff (rst)
    vreq.go |-> (state == ehvm_pkg::ST_READ))
    else $error("velocity unit started outside read step");

  a_vel_done_state: assert property (@(posedge clk) disable iff (rst)
    vrsp.done |-> (state == ehvm_pkg::ST_DIV))
    else $error("velocity result with no request waiting");

endmodule
